// ===== rtl/ffsk_pkg.sv =====
// Shared constants for the four-level FSK slicer: configuration port geometry,
// register indexes, reset values, dibit codes and rounding offsets. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffsk_pkg;

    // Configuration port geometry
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int FRAC_WIDTH      = 16;   // Q0.16 gate and weight
    localparam int INIT_WIDTH      = 15;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GATE   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_WEIGHT = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INIT   = 2'd2;

    // Register reset values
    localparam logic [FRAC_WIDTH-1:0] GATE_RESET   = 16'd45875;
    localparam logic [FRAC_WIDTH-1:0] WEIGHT_RESET = 16'd655;
    localparam logic [INIT_WIDTH-1:0] INIT_RESET   = 15'd16384;

    // Dibit codes
    localparam logic [1:0] CODE_POS_INNER = 2'd0;
    localparam logic [1:0] CODE_POS_OUTER = 2'd1;
    localparam logic [1:0] CODE_NEG_INNER = 2'd2;
    localparam logic [1:0] CODE_NEG_OUTER = 2'd3;

    // Rounding offsets for the Q0.16 averaging step (half toward plus infinity)
    localparam int ROUND_UP_OFFSET   = 32768;
    localparam int ROUND_DOWN_OFFSET = 32767;

endpackage

`default_nettype wire

// ===== rtl/four_level_fsk_slicer_unit.sv =====
// Four-level FSK dibit slicer with adaptive outer-level tracking. Depends on ffsk_pkg.
// Path: an accepted word passes the input register, then the result register on m_*;
//   it waits in the input register while the gate thresholds are being refreshed.
// Throughput: one word per cycle while levels hold and m_* keeps up; a level move,
//   or a gate or initial-level write, stalls the next word until thresholds refresh.
// Reset (aresetn low, synchronous): defaults, levels +/-16384, pipeline empty.
`timescale 1ns / 1ps
`default_nettype none

module four_level_fsk_slicer_unit
    import ffsk_pkg::*;
#(
    parameter int SAMPLE_WIDTH        = 16,
    parameter int LEVEL_FRACTION_BITS = 8
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input words
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire signed [SAMPLE_WIDTH-1:0]    s_sample,
    // result words
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [1:0]                       m_dibit_code,
    // configuration writes
    input  wire                              cfg_wr_en,
    input  wire [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  wire [CFG_DATA_WIDTH-1:0]         cfg_data
);

    localparam int W  = SAMPLE_WIDTH;
    localparam int F  = LEVEL_FRACTION_BITS;
    localparam int LW = W + F;                 // level width
    localparam int PW = LW + FRAC_WIDTH + 1;   // gate product width

    localparam logic signed [LW-1:0] LEVEL_MAX = {1'b0, {(LW-1){1'b1}}};
    localparam logic signed [LW-1:0] LEVEL_MIN = {1'b1, {(LW-1){1'b0}}};
    localparam logic [LW+16:0] RND_UP   = (LW+17)'(ROUND_UP_OFFSET);
    localparam logic [LW+16:0] RND_DOWN = (LW+17)'(ROUND_DOWN_OFFSET);

    // Initial magnitude with fraction bits, saturated to the level range
    function automatic logic signed [LW-1:0] load_magnitude(input logic [INIT_WIDTH-1:0] v);
        logic overflow;
        overflow = |(v >> (W - 1));
        load_magnitude = overflow ? LEVEL_MAX : (LW'(v) << F);
    endfunction

    // Level moved toward target by weight, rounded, saturated
    function automatic logic signed [LW-1:0] average_toward(
        input logic signed [LW-1:0] level,
        input logic signed [LW-1:0] target,
        input logic [FRAC_WIDTH-1:0] weight
    );
        logic signed [LW:0]   diff;
        logic [LW:0]          mag;
        logic [LW+16:0]       prod;
        logic [LW+16:0]       rounded;
        logic [LW:0]          step;
        logic signed [LW+1:0] sum;
        diff = {target[LW-1], target} - {level[LW-1], level};
        mag  = diff[LW] ? (LW+1)'(-diff) : diff;
        prod = (LW+17)'(mag) * (LW+17)'(weight);
        rounded = prod + (diff[LW] ? RND_DOWN : RND_UP);
        step = rounded[LW+16:16];
        if (diff[LW]) begin
            sum = {{2{level[LW-1]}}, level} - {1'b0, step};
        end else begin
            sum = {{2{level[LW-1]}}, level} + {1'b0, step};
        end
        if (sum > LEVEL_MAX) begin
            average_toward = LEVEL_MAX;
        end else if (sum < LEVEL_MIN) begin
            average_toward = LEVEL_MIN;
        end else begin
            average_toward = sum[LW-1:0];
        end
    endfunction

    // Configuration and level state
    logic [FRAC_WIDTH-1:0]  gate_reg;
    logic [FRAC_WIDTH-1:0]  weight_reg;
    logic signed [LW-1:0]   pos_level_reg, pos_level_next;
    logic signed [LW-1:0]   neg_level_reg, neg_level_next;

    // Gate thresholds: gate * level, refreshed after any level or gate change
    logic signed [PW-1:0]   thr_pos_reg, thr_neg_reg;
    logic                   thr_valid_reg;

    // Input and result registers
    logic                   in_valid_reg;
    logic signed [W-1:0]    in_sample_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_code_reg, out_code_next;

    logic                   proc_fire;
    logic                   upd_pos, upd_neg;
    logic signed [LW-1:0]   sample_fix;
    logic signed [PW-1:0]   sample_gate;
    logic signed [LW:0]     sample_twice;
    logic signed [LW-1:0]   avg_pos, avg_neg;
    logic signed [PW-1:0]   thr_pos_calc, thr_neg_calc;
    logic signed [LW-1:0]   init_mag;

    // Handshake
    assign proc_fire = in_valid_reg && thr_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || proc_fire;
    assign m_valid   = out_valid_reg;
    assign m_dibit_code = out_code_reg;

    // Sample in level format and gate format
    assign sample_fix   = LW'(in_sample_reg) <<< F;
    assign sample_gate  = PW'(sample_fix) <<< FRAC_WIDTH;
    assign sample_twice = {sample_fix, 1'b0};

    // Gate tests against the stored thresholds; at most one level moves
    assign upd_pos = sample_gate > thr_pos_reg;
    assign upd_neg = !upd_pos && (sample_gate < thr_neg_reg);

    assign avg_pos = average_toward(pos_level_reg, sample_fix, weight_reg);
    assign avg_neg = average_toward(neg_level_reg, sample_fix, weight_reg);

    assign thr_pos_calc = $signed({1'b0, gate_reg}) * pos_level_reg;
    assign thr_neg_calc = $signed({1'b0, gate_reg}) * neg_level_reg;

    assign init_mag = load_magnitude(cfg_data[INIT_WIDTH-1:0]);

    // Updated levels and slicing against them
    always_comb begin
        pos_level_next = (proc_fire && upd_pos) ? avg_pos : pos_level_reg;
        neg_level_next = (proc_fire && upd_neg) ? avg_neg : neg_level_reg;
        if (sample_twice >= pos_level_next) begin
            out_code_next = CODE_POS_OUTER;
        end else if (!sample_fix[LW-1]) begin
            out_code_next = CODE_POS_INNER;
        end else if (sample_twice >= neg_level_next) begin
            out_code_next = CODE_NEG_INNER;
        end else begin
            out_code_next = CODE_NEG_OUTER;
        end
    end

    // Configuration, levels and thresholds
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_reg      <= GATE_RESET;
            weight_reg    <= WEIGHT_RESET;
            pos_level_reg <= load_magnitude(INIT_RESET);
            neg_level_reg <= -load_magnitude(INIT_RESET);
            thr_valid_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GATE: begin
                    gate_reg      <= cfg_data;
                    thr_valid_reg <= 1'b0;
                end
                REG_WEIGHT: begin
                    weight_reg <= cfg_data;
                end
                REG_INIT: begin
                    pos_level_reg <= init_mag;
                    neg_level_reg <= -init_mag;
                    thr_valid_reg <= 1'b0;
                end
                default: begin
                end
            endcase
        end else begin
            pos_level_reg <= pos_level_next;
            neg_level_reg <= neg_level_next;
            if (!thr_valid_reg) begin
                thr_pos_reg   <= thr_pos_calc;
                thr_neg_reg   <= thr_neg_calc;
                thr_valid_reg <= 1'b1;
            end else if (proc_fire && (upd_pos || upd_neg)) begin
                thr_valid_reg <= 1'b0;
            end
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg  <= 1'b1;
            in_sample_reg <= s_sample;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire) begin
            out_valid_reg <= 1'b1;
            out_code_reg  <= out_code_next;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Level tracking never crosses zero
    a_pos_level_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        !pos_level_reg[LW-1])
        else $error("positive level went negative");

    a_neg_level_nonpos: assert property (@(posedge aclk) disable iff (!aresetn)
        (neg_level_reg[LW-1] || (neg_level_reg == '0)))
        else $error("negative level went positive");

    // A processed word always lands in the result register
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire |=> out_valid_reg)
        else $error("processed word produced no result");

endmodule

`default_nettype wire
